// ===== rtl/crcfv_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfv_pkg - shared types and constants for the CRC-16 frame validator
// Holds the CRC-16/MODBUS byte update, framing constants and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfv_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_LSB  = 16'h0001;

	// shortest frame: address, function, length, CRC low, CRC high
	localparam int unsigned MIN_FRAME_BYTES = 5;
	// bytes in a frame beyond those counted by the length field
	localparam int unsigned FRAME_OVERHEAD  = 5;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned CRC_W    = 16;
	localparam int unsigned FBYTES_W = 11;
	localparam int unsigned RES_W    = 3 + CRC_W + FBYTES_W;
	localparam int unsigned TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic [FBYTES_W-1:0] frame_bytes;
		logic [CRC_W-1:0]    computed_crc;
		logic                length_ok;
		logic                crc_ok;
		logic                frame_ok;
	} result_t;

	// reflected CRC-16 update, one byte, eight unrolled shift steps
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
			input logic [DATA_W-1:0] b);
		logic [CRC_W-1:0] v;
		v = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if ((v & CRC_LSB) != '0) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crcfv_tracker.sv =====
// ----------------------------------------------------------------------------
// crcfv_tracker - per-frame state and end-of-frame checks
// Running CRC, byte count, two-byte trailer delay and length field capture.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfv_tracker #(
	parameter int unsigned MAX_FRAME_BYTES = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,      // consume one byte
	input  wire logic [crcfv_pkg::DATA_W-1:0]    data_byte,
	input  wire logic                            last_byte,
	output crcfv_pkg::result_t                   result
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned CMP_W = (CNT_W > 9) ? CNT_W : 9;
	localparam int unsigned EXT_W = (CNT_W > crcfv_pkg::FBYTES_W) ? CNT_W
		: crcfv_pkg::FBYTES_W;

	logic [crcfv_pkg::CRC_W-1:0]  crc_q, crc_n;
	logic [CNT_W-1:0]             cnt_q, cnt_n;
	logic                         ovf_q, ovf_n;
	logic [crcfv_pkg::DATA_W-1:0] dly0_q, dly1_q;
	logic [crcfv_pkg::DATA_W-1:0] len_q, len_n;
	logic                         long_enough;
	logic [EXT_W-1:0]             cnt_ext;

	always_comb begin
		crc_n = (cnt_q >= CNT_W'(2)) ? crcfv_pkg::crc_byte(crc_q, dly0_q) : crc_q;
		len_n = (cnt_q == CNT_W'(2)) ? data_byte : len_q;
		if (cnt_q < CNT_W'(MAX_FRAME_BYTES)) begin
			cnt_n = cnt_q + CNT_W'(1);
			ovf_n = ovf_q;
		end else begin
			cnt_n = cnt_q;
			ovf_n = 1'b1;
		end
	end

	assign long_enough = CMP_W'(cnt_n) >= CMP_W'(crcfv_pkg::MIN_FRAME_BYTES);
	assign cnt_ext     = EXT_W'(cnt_n);

	// trailer is dly1 (CRC low) then the current byte (CRC high)
	always_comb begin
		result.crc_ok = long_enough && (dly1_q == crc_n[7:0])
			&& (data_byte == crc_n[15:8]);
		result.length_ok = long_enough && !ovf_n
			&& (CMP_W'(cnt_n) == CMP_W'(len_n) + CMP_W'(crcfv_pkg::FRAME_OVERHEAD));
		result.frame_ok     = result.crc_ok && result.length_ok;
		result.computed_crc = crc_n;
		result.frame_bytes  = cnt_ext[crcfv_pkg::FBYTES_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= crcfv_pkg::CRC_INIT;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			dly0_q <= '0;
			dly1_q <= '0;
			len_q  <= '0;
		end else if (step) begin
			dly0_q <= dly1_q;
			dly1_q <= data_byte;
			len_q  <= len_n;
			if (last_byte) begin
				crc_q <= crcfv_pkg::CRC_INIT;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				crc_q <= crc_n;
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crc16_frame_validator_top.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_validator_top - CRC-16/MODBUS frame checker, one byte per beat
// Input beat register, frame tracker and a result register on the output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the received frame, one byte per beat, tlast on the final
//   byte. Every byte except the last two feeds a running CRC-16/MODBUS
//   (init 0xFFFF, reflected poly 0xA001); the last two bytes are the CRC,
//   low byte first. Byte 2 of the frame is the length field.
//   m_axis gives one result beat per frame, after the tlast byte:
//   CRC check, length check (total = length + 5), their AND, the computed
//   CRC and the byte count (saturating at MAX_FRAME_BYTES). Frames shorter
//   than five bytes, or longer than MAX_FRAME_BYTES, fail.
//   Path: with m_axis free, the tlast beat moves from the input register
//   into the result register, which then presents the result beat.
//   Throughput: one byte per cycle unless a final byte waits on a held
//   result; the eight-step CRC update is combinational in the tracker.
//   Stall: non-final bytes never wait on m_axis; a final byte waits in the
//   input register only while a previous result is still held, and
//   s_axis_tready drops once that register is full as well.
//   Reset (arst_n low, asynchronous): pipeline empties, CRC returns to
//   0xFFFF, byte count, trailer delay and length field clear.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_validator_top #(
	parameter int unsigned MAX_FRAME_BYTES = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	input  wire logic [crcfv_pkg::DATA_W-1:0]          s_axis_tdata,  // [7:0] data_byte
	input  wire logic                                  s_axis_tlast,  // last_byte
	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [0] frame_ok, [1] crc_ok, [2] length_ok, [18:3] computed_crc,
	// [29:19] frame_bytes, [31:30] zero
	output      logic [crcfv_pkg::TDATA_OUT_W-1:0]     m_axis_tdata
);

	// input beat register
	logic                         vld_s1;
	logic [crcfv_pkg::DATA_W-1:0] data_s1;
	logic                         last_s1;

	// result register
	logic                         vld_s2;
	crcfv_pkg::result_t           res_s2;

	crcfv_pkg::result_t           res_comb;
	logic                         out_free;
	logic                         step_s1;

	// result slot is free when empty or being drained this cycle
	assign out_free      = !vld_s2 || m_axis_tready;
	// non-final bytes produce no result, so they never wait on the output
	assign step_s1       = vld_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !vld_s1 || step_s1;

	crcfv_tracker #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step_s1),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (step_s1 && last_s1) begin
				vld_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (step_s1 && last_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = crcfv_pkg::TDATA_OUT_W'(res_s2);

endmodule

`default_nettype wire
